// ===== sv/kst_pkg.sv =====
package kst_pkg;

  // Table geometry.
  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // Field widths of the words on the channels.
  localparam int OP_W        = 2;
  localparam int ID_W        = 32;
  localparam int SRC_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 3;
  localparam int COUNT_OUT_W = 4;
  localparam int ENTRY_W     = ID_W + SRC_W;

  // Operation codes; the unused code behaves as a list.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  // Source classes.
  localparam logic [SRC_W-1:0] SRC_NONE   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LISTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [ID_W-1:0]  entry_id;
    logic [SRC_W-1:0] source_class;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   remove_ok;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [ID_W-1:0]        out_id;
    logic [SRC_W-1:0]       out_source;
    logic [ID_W-1:0]        evicted_id;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   newest_present;
    logic [ID_W-1:0]        peak_id;
    logic                   last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_op;
    logic [IDX_W-1:0] rd_addr;
    logic             acc_en;
    logic [IDX_W-1:0] acc_idx;
    logic             commit;
    logic             list_ld;
    logic [IDX_W-1:0] list_slot;
    logic             list_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             op_list;
    logic [SLOTS-1:0] valid_vec;
    logic             empty;
    logic             out_free;
  } dp_sts_t;

endpackage

// ===== sv/kst_if.sv =====
interface kst_in_if;
  import kst_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [ID_W-1:0]  entry_id;
  logic [SRC_W-1:0] source_class;

  modport source (output valid, opcode, entry_id, source_class, input ready);
  modport sink   (input valid, opcode, entry_id, source_class, output ready);
endinterface

interface kst_out_if;
  import kst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic                   remove_ok;
  logic [SLOT_OUT_W-1:0]  slot;
  logic [ID_W-1:0]        out_id;
  logic [SRC_W-1:0]       out_source;
  logic [ID_W-1:0]        evicted_id;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   newest_present;
  logic [ID_W-1:0]        peak_id;
  logic                   last;

  modport source (
    output valid, status, remove_ok, slot, out_id, out_source, evicted_id,
           entry_count, newest_present, peak_id, last,
    input  ready
  );
  modport sink (
    input  valid, status, remove_ok, slot, out_id, out_source, evicted_id,
           entry_count, newest_present, peak_id, last,
    output ready
  );
endinterface

// ===== sv/kst_ram.sv =====
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/kst_datapath.sv =====
module kst_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kst_pkg::in_word_t   in_word_i,
  input  kst_pkg::dp_cmd_t    cmd_i,
  output kst_pkg::dp_sts_t    sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kst_pkg::out_word_t  out_word_o
);
  import kst_pkg::*;

  // Table control state.
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Operation under way.
  logic [OP_W-1:0]  op_q;
  logic [ID_W-1:0]  op_id_q;
  logic [SRC_W-1:0] op_src_q;

  // Scan accumulators.
  logic             min_found_q, min_found_d;
  logic [ID_W-1:0]  min_id_q, min_id_d;
  logic [IDX_W-1:0] min_idx_q, min_idx_d;
  logic             match_found_q, match_found_d;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic [SRC_W-1:0] match_src_q, match_src_d;
  logic             have1_q, have1_d;
  logic [ID_W-1:0]  max1_q, max1_d;
  logic             dup_q, dup_d;
  logic             have2_q, have2_d;
  logic [ID_W-1:0]  max2_q, max2_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  // Memory read side.
  logic [ENTRY_W-1:0] rdata;
  logic [ID_W-1:0]    rd_id;
  logic [SRC_W-1:0]   rd_src;

  // Commit side.
  logic             is_add, is_rem;
  logic             has_free;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] add_idx;
  logic             add_rest_have;
  logic [ID_W-1:0]  add_newest;
  logic             rem_have;
  logic [ID_W-1:0]  rem_newest;
  logic             ram_we;
  out_word_t        res_commit, res_list;

  assign is_add = (op_q == OP_ADD);
  assign is_rem = (op_q == OP_REMOVE);

  kst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (add_idx),
    .wdata_i ({op_id_q, op_src_q}),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign rd_id  = rdata[ENTRY_W-1:SRC_W];
  assign rd_src = rdata[SRC_W-1:0];
  assign ram_we = cmd_i.commit && is_add;

  // Capture the input word; an unknown source class is stored as none.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      op_q     <= in_word_i.opcode;
      op_id_q  <= in_word_i.entry_id;
      op_src_q <= (in_word_i.source_class == SRC_UNUSED) ? SRC_NONE
                                                         : in_word_i.source_class;
    end
  end

  // Per-slot accumulation: oldest, first match, largest and second largest id.
  always_comb begin
    min_found_d   = min_found_q;
    min_id_d      = min_id_q;
    min_idx_d     = min_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    match_src_d   = match_src_q;
    have1_d       = have1_q;
    max1_d        = max1_q;
    dup_d         = dup_q;
    have2_d       = have2_q;
    max2_d        = max2_q;
    if (cmd_i.load_op) begin
      min_found_d   = 1'b0;
      match_found_d = 1'b0;
      have1_d       = 1'b0;
      have2_d       = 1'b0;
      dup_d         = 1'b0;
    end else if (cmd_i.acc_en && valid_q[cmd_i.acc_idx]) begin
      if (!min_found_q || rd_id < min_id_q) begin
        min_found_d = 1'b1;
        min_id_d    = rd_id;
        min_idx_d   = cmd_i.acc_idx;
      end
      if (!match_found_q && rd_id == op_id_q) begin
        match_found_d = 1'b1;
        match_idx_d   = cmd_i.acc_idx;
        match_src_d   = rd_src;
      end
      if (!have1_q || rd_id > max1_q) begin
        have2_d = have1_q;
        max2_d  = max1_q;
        have1_d = 1'b1;
        max1_d  = rd_id;
        dup_d   = 1'b0;
      end else if (rd_id == max1_q) begin
        dup_d = 1'b1;
      end else if (!have2_q || rd_id > max2_q) begin
        have2_d = 1'b1;
        max2_d  = rd_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_found_q   <= 1'b0;
      match_found_q <= 1'b0;
      have1_q       <= 1'b0;
      have2_q       <= 1'b0;
      dup_q         <= 1'b0;
    end else begin
      min_found_q   <= min_found_d;
      match_found_q <= match_found_d;
      have1_q       <= have1_d;
      have2_q       <= have2_d;
      dup_q         <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_id_q    <= min_id_d;
    min_idx_q   <= min_idx_d;
    match_idx_q <= match_idx_d;
    match_src_q <= match_src_d;
    max1_q      <= max1_d;
    max2_q      <= max2_d;
  end

  // Lowest free slot.
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // An add fills a free slot or reuses the oldest one. When the oldest is
  // dropped from a full table, the largest id survives unless it was alone.
  assign add_idx       = has_free ? free_idx : min_idx_q;
  assign add_rest_have = has_free ? have1_q : (cnt_q > CNT_W'(1));
  assign add_newest    = (add_rest_have && max1_q > op_id_q) ? max1_q : op_id_q;

  // Largest id left after clearing one entry holding the removed id.
  always_comb begin
    rem_have   = 1'b1;
    rem_newest = max1_q;
    if (op_id_q == max1_q && !dup_q) begin
      rem_have   = have2_q;
      rem_newest = have2_q ? max2_q : '0;
    end
  end

  // Result word and table update for add, remove and the empty list.
  always_comb begin
    res_commit      = '0;
    res_commit.last = 1'b1;
    valid_d         = valid_q;
    cnt_d           = cnt_q;
    if (is_add) begin
      res_commit.status         = has_free ? ST_ADDED : ST_EVICTED;
      res_commit.slot           = SLOT_OUT_W'(add_idx);
      res_commit.out_id         = op_id_q;
      res_commit.out_source     = op_src_q;
      res_commit.evicted_id     = has_free ? '0 : min_id_q;
      res_commit.newest_present = 1'b1;
      res_commit.peak_id        = add_newest;
      if (cmd_i.commit) begin
        valid_d[add_idx] = 1'b1;
        cnt_d            = has_free ? cnt_q + CNT_W'(1) : cnt_q;
      end
    end else if (is_rem) begin
      res_commit.status = ST_REMOVE;
      if (match_found_q) begin
        res_commit.remove_ok      = 1'b1;
        res_commit.slot           = SLOT_OUT_W'(match_idx_q);
        res_commit.out_id         = op_id_q;
        res_commit.out_source     = match_src_q;
        res_commit.newest_present = rem_have;
        res_commit.peak_id        = rem_newest;
        if (cmd_i.commit) begin
          valid_d[match_idx_q] = 1'b0;
          cnt_d                = cnt_q - CNT_W'(1);
        end
      end else begin
        res_commit.newest_present = have1_q;
        res_commit.peak_id        = have1_q ? max1_q : '0;
      end
    end else begin
      res_commit.status = ST_EMPTY;
    end
    res_commit.entry_count = COUNT_OUT_W'(cnt_d);
  end

  // One listed entry, read from the memory.
  always_comb begin
    res_list                = '0;
    res_list.status         = ST_LISTED;
    res_list.slot           = SLOT_OUT_W'(cmd_i.list_slot);
    res_list.out_id         = rd_id;
    res_list.out_source     = rd_src;
    res_list.entry_count    = COUNT_OUT_W'(cnt_q);
    res_list.newest_present = have1_q;
    res_list.peak_id        = have1_q ? max1_q : '0;
    res_list.last           = cmd_i.list_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register: a new word may load in the cycle the old one leaves.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      out_d       = res_commit;
    end else if (cmd_i.list_ld) begin
      out_valid_d = 1'b1;
      out_d       = res_list;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign sts_o.op_list   = !(is_add || is_rem);
  assign sts_o.valid_vec = valid_q;
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // The entry count always agrees with the valid bits.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(valid_q)))
    else $error("entry count differs from valid bits");

  // A new word is loaded only when the previous one is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.list_ld) |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten");

  // An add leaves its slot valid.
  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && is_add) |=> valid_q[$past(add_idx)])
    else $error("added slot not valid");

endmodule

// ===== sv/kst_ctrl.sv =====
module kst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kst_pkg::dp_sts_t  sts_i,
  output kst_pkg::dp_cmd_t  cmd_o
);
  import kst_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_WAIT    = 3'd2;
  localparam logic [2:0] S_COMMIT  = 3'd3;
  localparam logic [2:0] S_LIST_RD = 3'd4;
  localparam logic [2:0] S_LIST_LD = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             acc_vld_q, acc_vld_d;
  logic [IDX_W-1:0] acc_idx_q, acc_idx_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [RES_W-1:0] sent_q, sent_d;

  logic [IDX_W-1:0] nxt_idx;
  logic             more_after;
  logic             list_last;

  // Next valid slot at or after the list pointer.
  always_comb begin
    nxt_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (sts_i.valid_vec[i] && IDX_W'(i) >= ptr_q) begin
        nxt_idx = IDX_W'(i);
      end
    end
  end

  // Whether any valid slot follows the one being listed.
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sts_i.valid_vec[i] && IDX_W'(i) > cur_q) begin
        more_after = 1'b1;
      end
    end
  end

  assign list_last = !more_after || (sent_q == RES_W'(MAX_RESULTS - 1));

  // Sequencer: scan all slots, then commit one word or list the entries.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_vld_d = 1'b0;
    acc_idx_d = acc_idx_q;
    cur_d     = cur_q;
    ptr_d     = ptr_q;
    sent_d    = sent_q;
    in_ready_o = 1'b0;

    cmd_o           = '0;
    cmd_o.rd_addr   = cnt_q;
    cmd_o.acc_en    = acc_vld_q;
    cmd_o.acc_idx   = acc_idx_q;
    cmd_o.list_slot = cur_q;
    cmd_o.list_last = list_last;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          cnt_d         = '0;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        acc_vld_d = 1'b1;
        acc_idx_d = cnt_q;
        if (cnt_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_WAIT;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (sts_i.op_list && !sts_i.empty) begin
          ptr_d   = '0;
          sent_d  = '0;
          state_d = S_LIST_RD;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_LIST_RD: begin
        cmd_o.rd_addr = nxt_idx;
        cur_d         = nxt_idx;
        state_d       = S_LIST_LD;
      end
      S_LIST_LD: begin
        cmd_o.rd_addr = cur_q;
        if (sts_i.out_free) begin
          cmd_o.list_ld = 1'b1;
          sent_d        = sent_q + RES_W'(1);
          ptr_d         = cur_q + IDX_W'(1);
          state_d       = list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      acc_vld_q <= 1'b0;
      acc_idx_q <= '0;
      cur_q     <= '0;
      ptr_q     <= '0;
      sent_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      acc_vld_q <= acc_vld_d;
      acc_idx_q <= acc_idx_d;
      cur_q     <= cur_d;
      ptr_q     <= ptr_d;
      sent_q    <= sent_d;
    end
  end

  // Only valid slots are listed.
  a_list_valid_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST_LD) |-> sts_i.valid_vec[cur_q])
    else $error("listing a free slot");

  // A list over a non-empty table never ends in a single commit word.
  a_list_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(sts_i.op_list && !sts_i.empty))
    else $error("non-empty list committed as one word");

  // The last slot read of a scan is followed by accumulation of its data.
  a_scan_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (acc_vld_q && acc_idx_q == IDX_W'(SLOTS - 1)))
    else $error("scan tail not accumulated");

endmodule

// ===== sv/keyed_slot_table_evict_oldest_top.sv =====
// Channel  Dir  Words
// in_i     in   opcode, entry_id, source_class
// out_o    out  status, remove_ok, slot, out_id, out_source, evicted_id,
//               entry_count, newest_present, peak_id, last
//
// Add and remove go from acceptance to the next accept through the accept
// step, one memory read per slot, a wait step for the last read data and
// one commit. An empty list takes the same path as a remove.
// A non-empty list scans every slot the same way and then reads and loads
// each listed entry in turn.
// Reset clears the valid bits and the count; slot contents need no clearing.
// A stalled output holds the sequencer in its commit or load step; the next
// word is taken as soon as the sequencer returns to idle.
module keyed_slot_table_evict_oldest_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  kst_in_if.sink     in_i,
  kst_out_if.source  out_o
);
  import kst_pkg::*;

  in_word_t  in_word;
  out_word_t out_word;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      out_valid;

  assign in_word.opcode       = in_i.opcode;
  assign in_word.entry_id     = in_i.entry_id;
  assign in_word.source_class = in_i.source_class;

  kst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  assign out_o.valid          = out_valid;
  assign out_o.status         = out_word.status;
  assign out_o.remove_ok      = out_word.remove_ok;
  assign out_o.slot           = out_word.slot;
  assign out_o.out_id         = out_word.out_id;
  assign out_o.out_source     = out_word.out_source;
  assign out_o.evicted_id     = out_word.evicted_id;
  assign out_o.entry_count    = out_word.entry_count;
  assign out_o.newest_present = out_word.newest_present;
  assign out_o.peak_id        = out_word.peak_id;
  assign out_o.last           = out_word.last;

endmodule
